### hdl/rsc_pkg.sv
// Shared types and constants for the postfix calculator stack.
// Used by every module under hdl except rsc_ram; depends on nothing.
package rsc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int QDIV_W      = VAL_W + FRAC_W;
  localparam int WIDE_W      = 64;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [2:0] CMD_PUSH  = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_SUB   = 3'd2;
  localparam logic [2:0] CMD_MUL   = 3'd3;
  localparam logic [2:0] CMD_DIV   = 3'd4;
  localparam logic [2:0] CMD_CLEAR = 3'd5;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
  localparam logic [2:0] ERR_DIVZERO   = 3'd3;
  localparam logic [2:0] ERR_SATURATED = 3'd4;

  localparam logic [1:0] CLS_ZERO_ONE  = 2'd0;
  localparam logic [1:0] CLS_ZERO_DEEP = 2'd1;
  localparam logic [1:0] CLS_NZ_DEEP   = 2'd2;
  localparam logic [1:0] CLS_NZ_ONE    = 2'd3;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] operand;
  } q_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic              start;
    logic [QDIV_W-1:0] dividend;
    logic [VAL_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             sat;
    logic [VAL_W-1:0] val;
  } sat_res_t;

endpackage

### hdl/rsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/rsc_front.sv
// Front end: accepts commands, decodes them and holds them in a short queue.
// Depends on rsc_pkg for the queue word and operation codes.
module rsc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    command,
  input  logic signed [rsc_pkg::VAL_W-1:0] operand_value,
  output logic                          q_valid,
  input  logic                          q_pop,
  output rsc_pkg::q_item_t              q_item
);

  rsc_pkg::q_item_t            fifo [rsc_pkg::QDEPTH];
  logic [rsc_pkg::QPTR_W-1:0]  wr_ptr;
  logic [rsc_pkg::QPTR_W-1:0]  rd_ptr;
  logic [rsc_pkg::QCNT_W-1:0]  count;
  logic [rsc_pkg::QCNT_W-1:0]  count_next;
  logic                        push;
  rsc_pkg::op_t                op_dec;

  always_comb begin
    case (command)
      rsc_pkg::CMD_PUSH:  op_dec = rsc_pkg::OP_PUSH;
      rsc_pkg::CMD_ADD:   op_dec = rsc_pkg::OP_ADD;
      rsc_pkg::CMD_SUB:   op_dec = rsc_pkg::OP_SUB;
      rsc_pkg::CMD_MUL:   op_dec = rsc_pkg::OP_MUL;
      rsc_pkg::CMD_DIV:   op_dec = rsc_pkg::OP_DIV;
      rsc_pkg::CMD_CLEAR: op_dec = rsc_pkg::OP_CLEAR;
      default:            op_dec = rsc_pkg::OP_NOP;
    endcase
  end

  assign in_stall = (count == rsc_pkg::QCNT_W'(rsc_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = fifo[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + rsc_pkg::QCNT_W'(1);
    end else if (q_pop && !push) begin
      count_next = count - rsc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{op: op_dec, operand: operand_value};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rsc_pkg::QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + rsc_pkg::QPTR_W'(1);
      end
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rsc_pkg::QCNT_W'(rsc_pkg::QDEPTH))
    else $error("queue count beyond its depth");
`endif

endmodule

### hdl/rsc_div.sv
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit a cycle.
// Depends on rsc_pkg for the operand widths and request word.
module rsc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  rsc_pkg::div_req_t           req,
  output logic                        done,
  output logic [rsc_pkg::QDIV_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(rsc_pkg::QDIV_W);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [rsc_pkg::QDIV_W-1:0] dvd;
  logic [rsc_pkg::VAL_W-1:0]  rem;
  logic [rsc_pkg::VAL_W-1:0]  dvs;
  logic [rsc_pkg::VAL_W:0]    shifted;
  logic [rsc_pkg::VAL_W:0]    diff;
  logic                       qbit;

  always_comb begin
    shifted = {rem, dvd[rsc_pkg::QDIV_W-1]};
    diff    = shifted - {1'b0, dvs};
    qbit    = (shifted >= {1'b0, dvs});
  end

  // quotient bits shift in behind the dividend bits
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == CNT_W'(rsc_pkg::QDIV_W - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        dvd <= {dvd[rsc_pkg::QDIV_W-2:0], qbit};
        rem <= qbit ? diff[rsc_pkg::VAL_W-1:0] : shifted[rsc_pkg::VAL_W-1:0];
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(rsc_pkg::QDIV_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider restarted while busy");
`endif

endmodule

### hdl/rsc_back.sv
// Back end: executes queued operations on the stack and registers each result.
// Depends on rsc_pkg; drives the stack RAM and the divider through request words.
module rsc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  rsc_pkg::q_item_t                  q_item,
  output rsc_pkg::ram_req_t                 ram_req,
  input  logic [rsc_pkg::VAL_W-1:0]         ram_rdata,
  output rsc_pkg::div_req_t                 div_req,
  input  logic                              div_done,
  input  logic [rsc_pkg::QDIV_W-1:0]        div_quot,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rsc_pkg::VAL_W-1:0]  top_value,
  output logic [4:0]                        stack_depth,
  output logic [1:0]                        state_class,
  output logic [2:0]                        error_code
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  localparam logic signed [rsc_pkg::WIDE_W-1:0] SAT_MAX =
    rsc_pkg::WIDE_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [rsc_pkg::WIDE_W-1:0] SAT_MIN =
    rsc_pkg::WIDE_W'(-64'sh0000_0000_8000_0000);
  localparam logic signed [rsc_pkg::WIDE_W-1:0] ROUND_ADJ =
    rsc_pkg::WIDE_W'((64'sd1 <<< rsc_pkg::FRAC_W) - 64'sd1);

  function automatic rsc_pkg::sat_res_t sat_wide(input logic signed [rsc_pkg::WIDE_W-1:0] v);
    rsc_pkg::sat_res_t r;
    if (v > SAT_MAX) begin
      r.sat = 1'b1;
      r.val = SAT_MAX[rsc_pkg::VAL_W-1:0];
    end else if (v < SAT_MIN) begin
      r.sat = 1'b1;
      r.val = SAT_MIN[rsc_pkg::VAL_W-1:0];
    end else begin
      r.sat = 1'b0;
      r.val = v[rsc_pkg::VAL_W-1:0];
    end
    return r;
  endfunction

  state_t                               state;
  rsc_pkg::op_t                         op;
  logic signed [rsc_pkg::VAL_W-1:0]     top;
  logic [rsc_pkg::DEPTH_W-1:0]          depth;
  logic [2:0]                           err;
  logic signed [rsc_pkg::WIDE_W-1:0]    prod;
  logic                                 div_neg;

  logic                                 is_arith;
  logic                                 full;
  logic                                 single;
  logic signed [rsc_pkg::VAL_W-1:0]     a_val;
  logic signed [rsc_pkg::WIDE_W-1:0]    a_ext;
  logic signed [rsc_pkg::WIDE_W-1:0]    b_ext;
  logic [rsc_pkg::VAL_W-1:0]            a_mag;
  logic [rsc_pkg::VAL_W-1:0]            b_mag;
  logic signed [rsc_pkg::WIDE_W-1:0]    mul_shr;
  logic [rsc_pkg::WIDE_W-1:0]           quot_ext;
  logic signed [rsc_pkg::WIDE_W-1:0]    div_sv;
  logic signed [rsc_pkg::WIDE_W-1:0]    res_in;
  rsc_pkg::sat_res_t                    res;

  assign is_arith = (q_item.op == rsc_pkg::OP_ADD) || (q_item.op == rsc_pkg::OP_SUB) ||
                    (q_item.op == rsc_pkg::OP_MUL) || (q_item.op == rsc_pkg::OP_DIV);
  assign full     = (depth == rsc_pkg::DEPTH_W'(rsc_pkg::STACK_DEPTH));
  assign single   = (depth == rsc_pkg::DEPTH_W'(1));
  assign q_pop    = (state == S_IDLE) && q_valid;

  // top of stack lives in a register; the RAM holds the entries beneath it
  always_comb begin
    ram_req.we    = q_pop && (q_item.op == rsc_pkg::OP_PUSH) && !full;
    ram_req.waddr = rsc_pkg::ADDR_W'(depth - rsc_pkg::DEPTH_W'(1));
    ram_req.wdata = top;
    ram_req.re    = q_pop && is_arith && !single &&
                    !((q_item.op == rsc_pkg::OP_DIV) && (top == '0));
    ram_req.raddr = rsc_pkg::ADDR_W'(depth - rsc_pkg::DEPTH_W'(2));
  end

  always_comb begin
    a_val    = ram_rdata;
    a_ext    = rsc_pkg::WIDE_W'(a_val);
    b_ext    = rsc_pkg::WIDE_W'(top);
    a_mag    = ram_rdata[rsc_pkg::VAL_W-1] ? (~ram_rdata + rsc_pkg::VAL_W'(1)) : ram_rdata;
    b_mag    = top[rsc_pkg::VAL_W-1] ? (~top + rsc_pkg::VAL_W'(1)) : top;
    // truncate towards zero: bias negative products before the arithmetic shift
    mul_shr  = $signed(prod + (prod[rsc_pkg::WIDE_W-1] ? ROUND_ADJ : SAT_MAX ^ SAT_MAX))
               >>> rsc_pkg::FRAC_W;
    quot_ext = rsc_pkg::WIDE_W'(div_quot);
    div_sv   = div_neg ? -$signed(quot_ext) : $signed(quot_ext);
    case (state)
      S_READ:  res_in = (op == rsc_pkg::OP_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
      S_MUL:   res_in = mul_shr;
      default: res_in = div_sv;
    endcase
    res = sat_wide(res_in);
  end

  always_comb begin
    div_req.start    = (state == S_READ) && (op == rsc_pkg::OP_DIV);
    div_req.dividend = {a_mag, rsc_pkg::FRAC_W'(0)};
    div_req.divisor  = b_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= rsc_pkg::OP_NOP;
      top       <= '0;
      depth     <= rsc_pkg::DEPTH_W'(1);
      err       <= rsc_pkg::ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            op <= q_item.op;
            case (q_item.op)
              rsc_pkg::OP_PUSH: begin
                state <= S_DONE;
                if (full) begin
                  err <= rsc_pkg::ERR_OVERFLOW;
                end else begin
                  err   <= rsc_pkg::ERR_NONE;
                  top   <= q_item.operand;
                  depth <= depth + rsc_pkg::DEPTH_W'(1);
                end
              end
              rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_MUL, rsc_pkg::OP_DIV: begin
                if (single) begin
                  err   <= rsc_pkg::ERR_UNDERFLOW;
                  state <= S_DONE;
                end else if ((q_item.op == rsc_pkg::OP_DIV) && (top == '0)) begin
                  err   <= rsc_pkg::ERR_DIVZERO;
                  state <= S_DONE;
                end else begin
                  err   <= rsc_pkg::ERR_NONE;
                  state <= S_READ;
                end
              end
              rsc_pkg::OP_CLEAR: begin
                err   <= rsc_pkg::ERR_NONE;
                state <= S_DONE;
                top   <= '0;
                depth <= rsc_pkg::DEPTH_W'(1);
              end
              default: begin
                err   <= rsc_pkg::ERR_NONE;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          case (op)
            rsc_pkg::OP_MUL: begin
              prod  <= a_ext * b_ext;
              state <= S_MUL;
            end
            rsc_pkg::OP_DIV: begin
              div_neg <= ram_rdata[rsc_pkg::VAL_W-1] ^ top[rsc_pkg::VAL_W-1];
              state   <= S_DIV;
            end
            default: begin
              top   <= res.val;
              depth <= depth - rsc_pkg::DEPTH_W'(1);
              err   <= res.sat ? rsc_pkg::ERR_SATURATED : rsc_pkg::ERR_NONE;
              state <= S_DONE;
            end
          endcase
        end
        S_MUL: begin
          top   <= res.val;
          depth <= depth - rsc_pkg::DEPTH_W'(1);
          err   <= res.sat ? rsc_pkg::ERR_SATURATED : rsc_pkg::ERR_NONE;
          state <= S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            top   <= res.val;
            depth <= depth - rsc_pkg::DEPTH_W'(1);
            err   <= res.sat ? rsc_pkg::ERR_SATURATED : rsc_pkg::ERR_NONE;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            top_value   <= top;
            stack_depth <= 5'(depth);
            error_code  <= err;
            if (top == '0) begin
              state_class <= single ? rsc_pkg::CLS_ZERO_ONE : rsc_pkg::CLS_ZERO_DEEP;
            end else begin
              state_class <= single ? rsc_pkg::CLS_NZ_ONE : rsc_pkg::CLS_NZ_DEEP;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    (depth != '0) && (depth <= rsc_pkg::DEPTH_W'(rsc_pkg::STACK_DEPTH)))
    else $error("stack depth out of range");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider result arrived outside the divide wait");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result loaded outside the done state");
`endif

endmodule

### hdl/rpn_stack_calculator.sv
// Postfix calculator stack, signed Q16.16, saturating, one result word per command.
// Push, clear, unused codes and errors go straight to the done state; add and subtract
// go via a read state, multiply via read and multiply states, divide via read and wait
// states. The back end holds one command at a time; the 48-step divider loop sets the
// worst case. Synchronous reset leaves a single zero on the stack, no clearing pass.
module rpn_stack_calculator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       command,
  input  logic signed [rsc_pkg::VAL_W-1:0] operand_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [rsc_pkg::VAL_W-1:0] top_value,
  output logic [4:0]                       stack_depth,
  output logic [1:0]                       state_class,
  output logic [2:0]                       error_code
);

  logic                               q_valid;
  logic                               q_pop;
  rsc_pkg::q_item_t                   q_item;
  rsc_pkg::ram_req_t                  ram_req;
  logic [rsc_pkg::VAL_W-1:0]          ram_rdata;
  rsc_pkg::div_req_t                  div_req;
  logic                               div_done;
  logic [rsc_pkg::QDIV_W-1:0]         div_quot;

  rsc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .operand_value (operand_value),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item)
  );

  rsc_ram #(
    .WIDTH (rsc_pkg::VAL_W),
    .DEPTH (rsc_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  rsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  rsc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .div_req     (div_req),
    .div_done    (div_done),
    .div_quot    (div_quot),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .top_value   (top_value),
    .stack_depth (stack_depth),
    .state_class (state_class),
    .error_code  (error_code)
  );

endmodule

### dv/tb_top.sv
// Self-checking testbench for the postfix calculator stack (rpn_stack_calculator).
// Holds its own Q16.16 stack predictor; drives valid/stall on both channels.
// Depends on hdl/rsc_pkg.sv and hdl/rpn_stack_calculator.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes 6 and 7 are not in the package: they are accepted and change nothing.
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam logic [31:0] Q_MAX_W   = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN_W   = 32'h8000_0000;
  localparam longint      Q_MAX     = 64'sd2147483647;
  localparam longint      Q_MIN     = -64'sd2147483648;
  localparam int          QUIET_MAX = 2000;
  localparam int          RAND_SEGS = 10;
  localparam int          SEG_ITEMS = 200;

  typedef struct {
    logic [31:0] top;
    logic [4:0]  depth;
    logic [1:0]  cls;
    logic [2:0]  err;
  } calc_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        command = rsc_pkg::CMD_PUSH;
  logic signed [31:0] operand_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [31:0] top_value;
  logic [4:0]        stack_depth;
  logic [1:0]        state_class;
  logic [2:0]        error_code;

  // Predictor state: a copy of the calculator stack.
  logic signed [31:0] calc_stack [rsc_pkg::STACK_DEPTH];
  int                 calc_depth = 1;
  calc_word_t         pending_results [$];

  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;
  int cmd_count [8];
  int err_count [5];
  int deepest = 1;

  rpn_stack_calculator dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .operand_value (operand_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .top_value     (top_value),
    .stack_depth   (stack_depth),
    .state_class   (state_class),
    .error_code    (error_code)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Work out the word one accepted command produces and update the stack copy.
  task automatic apply_command(input logic [2:0] cmd, input logic signed [31:0] val);
    longint     a;
    longint     b;
    longint     r;
    bit         commit;
    calc_word_t w;
    w.err = rsc_pkg::ERR_NONE;
    case (cmd)
      rsc_pkg::CMD_PUSH: begin
        if (calc_depth >= rsc_pkg::STACK_DEPTH) begin
          w.err = rsc_pkg::ERR_OVERFLOW;
        end else begin
          calc_stack[calc_depth] = val;
          calc_depth++;
        end
      end
      rsc_pkg::CMD_ADD, rsc_pkg::CMD_SUB, rsc_pkg::CMD_MUL, rsc_pkg::CMD_DIV: begin
        if (calc_depth < 2) begin
          w.err = rsc_pkg::ERR_UNDERFLOW;
        end else begin
          b = calc_stack[calc_depth-1];
          a = calc_stack[calc_depth-2];
          r = 0;
          commit = 1'b1;
          case (cmd)
            rsc_pkg::CMD_ADD: r = a + b;
            rsc_pkg::CMD_SUB: r = a - b;
            rsc_pkg::CMD_MUL: r = (a * b) / 65536;
            default: begin
              if (b == 0) begin
                commit = 1'b0;
                w.err = rsc_pkg::ERR_DIVZERO;
              end else begin
                r = (a * 65536) / b;
              end
            end
          endcase
          if (commit) begin
            if (r > Q_MAX) begin
              r = Q_MAX;
              w.err = rsc_pkg::ERR_SATURATED;
            end else if (r < Q_MIN) begin
              r = Q_MIN;
              w.err = rsc_pkg::ERR_SATURATED;
            end
            calc_stack[calc_depth-2] = r[31:0];
            calc_depth--;
          end
        end
      end
      rsc_pkg::CMD_CLEAR: begin
        calc_stack[0] = '0;
        calc_depth = 1;
      end
      default: ;
    endcase
    w.top   = calc_stack[calc_depth-1];
    w.depth = calc_depth[4:0];
    if (w.top == '0)
      w.cls = (calc_depth == 1) ? rsc_pkg::CLS_ZERO_ONE : rsc_pkg::CLS_ZERO_DEEP;
    else
      w.cls = (calc_depth == 1) ? rsc_pkg::CLS_NZ_ONE : rsc_pkg::CLS_NZ_DEEP;
    pending_results.push_back(w);
    cmd_count[cmd]++;
    err_count[w.err]++;
    if (calc_depth > deepest) deepest = calc_depth;
  endtask

  // Drive one command word and wait for it to be taken.
  task automatic send_word(input logic [2:0] cmd, input logic signed [31:0] val);
    int gap;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    command       <= cmd;
    operand_value <= val;
    do @(posedge clk); while (!(in_valid && !in_stall));
    apply_command(cmd, val);
  endtask

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = Q_MAX_W;
      2:       v = Q_MIN_W;
      3:       v = 32'($urandom_range(0, 100)) << 16;
      4:       v = -(32'($urandom_range(0, 100)) << 16);
      5:       v = 32'(int'($urandom_range(0, 2097152)) - 1048576);
      6:       v = $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic test_idle_commands();
    // Spare codes and arithmetic on a single entry straight after reset.
    send_word(CMD_SPARE6, $urandom());
    send_word(CMD_SPARE7, $urandom());
    send_word(rsc_pkg::CMD_ADD, $urandom());
    send_word(rsc_pkg::CMD_DIV, $urandom());
  endtask

  task automatic test_add_sub_saturation();
    send_word(rsc_pkg::CMD_CLEAR, '0);
    send_word(rsc_pkg::CMD_PUSH, Q_MAX_W);
    send_word(rsc_pkg::CMD_PUSH, 32'h0000_0001);
    send_word(rsc_pkg::CMD_ADD, '0);
    send_word(rsc_pkg::CMD_PUSH, Q_MIN_W);
    send_word(rsc_pkg::CMD_SUB, '0);
    send_word(rsc_pkg::CMD_PUSH, Q_MIN_W);
    send_word(rsc_pkg::CMD_ADD, '0);
    send_word(rsc_pkg::CMD_PUSH, Q_MIN_W);
    send_word(rsc_pkg::CMD_ADD, '0);
  endtask

  task automatic test_mul_div();
    send_word(rsc_pkg::CMD_CLEAR, '0);
    send_word(rsc_pkg::CMD_PUSH, 32'hFFFC_8000);   // -3.5
    send_word(rsc_pkg::CMD_PUSH, 32'h0002_4000);   // 2.25
    send_word(rsc_pkg::CMD_MUL, '0);
    send_word(rsc_pkg::CMD_PUSH, '0);
    send_word(rsc_pkg::CMD_DIV, '0);               // zero divisor, stack held
    send_word(rsc_pkg::CMD_SUB, '0);
    send_word(rsc_pkg::CMD_CLEAR, '0);
    send_word(rsc_pkg::CMD_PUSH, Q_MIN_W);
    send_word(rsc_pkg::CMD_PUSH, 32'h0000_0001);
    send_word(rsc_pkg::CMD_DIV, '0);               // clamps low
    send_word(rsc_pkg::CMD_PUSH, 32'hFFFF_FFFF);
    send_word(rsc_pkg::CMD_DIV, '0);               // clamps high
    send_word(rsc_pkg::CMD_PUSH, Q_MAX_W);
    send_word(rsc_pkg::CMD_MUL, '0);
  endtask

  task automatic test_full_stack();
    send_word(rsc_pkg::CMD_CLEAR, $urandom());
    repeat (rsc_pkg::STACK_DEPTH - 1) send_word(rsc_pkg::CMD_PUSH, pick_operand());
    send_word(rsc_pkg::CMD_PUSH, pick_operand());
    send_word(rsc_pkg::CMD_MUL, $urandom());
    send_word(rsc_pkg::CMD_PUSH, pick_operand());
  endtask

  task automatic test_random_mix();
    int          push_bias;
    int          roll;
    logic [2:0]  cmd;
    for (int seg = 0; seg < RAND_SEGS; seg++) begin
      // Vary the push share so the depth wanders over the whole stack.
      case ($urandom_range(0, 2))
        0:       push_bias = 40;
        1:       push_bias = 55;
        default: push_bias = 70;
      endcase
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      repeat (SEG_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < push_bias)  cmd = rsc_pkg::CMD_PUSH;
        else if (roll < 94)    cmd = rsc_pkg::CMD_ADD + 3'($urandom_range(0, 3));
        else if (roll < 97)    cmd = rsc_pkg::CMD_CLEAR;
        else                   cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
        send_word(cmd, pick_operand());
      end
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Check each result word against the oldest prediction.
  always @(posedge clk) begin : check_words
    calc_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%t: unexpected word top=%h depth=%0d class=%0d err=%0d",
                   $realtime, top_value, stack_depth, state_class, error_code);
      end else begin
        want = pending_results.pop_front();
        if (top_value !== want.top || stack_depth !== want.depth ||
            state_class !== want.cls || error_code !== want.err) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%t: mismatch exp top=%h depth=%0d class=%0d err=%0d",
                     $realtime, want.top, want.depth, want.cls, want.err);
            $display("%t:          got top=%h depth=%0d class=%0d err=%0d",
                     $realtime, top_value, stack_depth, state_class, error_code);
          end
        end
      end
      stall_left = sink_idle ? $urandom_range(0, 6) : 0;
    end
  end

  // Hold stall until the next word has waited its drawn number of cycles.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      if (out_valid) stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("Timeout: no word moved for %0d cycles", QUIET_MAX);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    foreach (calc_stack[i]) calc_stack[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_commands();
    test_add_sub_saturation();
    test_mul_div();
    test_full_stack();
    test_random_mix();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Let any stray word surface; a divide is the slowest command.
    repeat (80) @(posedge clk);

    $display("Covered: push %0d, add %0d, sub %0d, mul %0d, div %0d, clear %0d, spare %0d",
             cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4],
             cmd_count[5], cmd_count[6] + cmd_count[7]);
    $display("Flags: underflow %0d, overflow %0d, div by zero %0d, saturated %0d; deepest %0d",
             err_count[rsc_pkg::ERR_UNDERFLOW], err_count[rsc_pkg::ERR_OVERFLOW],
             err_count[rsc_pkg::ERR_DIVZERO], err_count[rsc_pkg::ERR_SATURATED], deepest);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
